### rtl/dns_hostname_checker_core_macros.svh
// Assertion macros for the checker file of the host name checker.
`ifndef DNS_HOSTNAME_CHECKER_CORE_MACROS_SVH
`define DNS_HOSTNAME_CHECKER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DHC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dhc same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dhc next-cycle check failed");

`endif

### rtl/dhc_pkg.sv
// Types and constants of the DNS host name checker.
package dhc_pkg;

    // Field widths.
    localparam int CHAR_W      = 8;
    localparam int STATUS_W    = 2;
    localparam int NAME_LEN_W  = 8;
    localparam int LABEL_LEN_W = 7;
    localparam int DOT_CNT_W   = 3;
    localparam int OUT_DATA_W  = 16;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LONG  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNSUP = 2'd3;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_COLON    = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_LBRACKET = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_RBRACKET = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_DOT      = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_HYPHEN   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_LOW_A    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOW_Z    = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UP_A     = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z     = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_ZERO     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE     = 8'h39;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

    // Dot count saturation and the dotted quad count.
    localparam logic [DOT_CNT_W-1:0] DOT_SAT  = 3'd4;
    localparam logic [DOT_CNT_W-1:0] DOT_QUAD = 3'd3;

    // Per-name checking state.
    typedef struct packed {
        logic [NAME_LEN_W-1:0]  name_len;
        logic [LABEL_LEN_W-1:0] label_len;
        logic [DOT_CNT_W-1:0]   dot_cnt;
        logic                   all_digits;
        logic                   prev_hyphen;
        logic [STATUS_W-1:0]    first_err;
        logic                   err_seen;
    } t_state;

    localparam t_state STATE_CLEAR = '{
        name_len:    '0,
        label_len:   '0,
        dot_cnt:     '0,
        all_digits:  1'b1,
        prev_hyphen: 1'b0,
        first_err:   ST_OK,
        err_seen:    1'b0
    };

    // One result beat.
    typedef struct packed {
        logic [CHAR_W-1:0]   lower_byte;
        logic [STATUS_W-1:0] status;
        logic                done_res;
    } t_result;

endpackage

### rtl/dhc_check.sv
// Per-byte host name rules: case folding, state update and final status.
module dhc_check
    import dhc_pkg::*;
#(
    parameter int MAX_NAME_LEN  = 253,
    parameter int MAX_LABEL_LEN = 63
) (
    input  t_state            i_state,
    input  logic [CHAR_W-1:0] i_char_byte,
    input  logic              i_no_char,
    input  logic              i_last,
    output t_state            o_state,
    output t_result           o_result
);

    localparam logic [NAME_LEN_W-1:0]  NAME_LIMIT  = NAME_LEN_W'(MAX_NAME_LEN);
    localparam logic [LABEL_LEN_W-1:0] LABEL_LIMIT = LABEL_LEN_W'(MAX_LABEL_LEN);

    // Fold the byte, apply the rules in order, then build the end-of-name status.
    always_comb begin
        t_state              s;
        logic [CHAR_W-1:0]   c;
        logic                letter;
        logic                digit;
        logic                hyphen;
        logic [STATUS_W-1:0] st;

        s = i_state;
        c = i_char_byte;
        if (c inside {[CH_UP_A:CH_UP_Z]}) begin
            c = c + CASE_OFFSET;
        end
        letter = c inside {[CH_LOW_A:CH_LOW_Z]};
        digit  = c inside {[CH_ZERO:CH_NINE]};
        hyphen = (c == CH_HYPHEN);

        if (!i_no_char) begin
            if (s.name_len <= NAME_LIMIT) begin
                s.name_len = s.name_len + NAME_LEN_W'(1);
            end
            // Once an error is held, bytes are only counted.
            if (!s.err_seen) begin
                if (c inside {CH_COLON, CH_LBRACKET, CH_RBRACKET}) begin
                    s.err_seen  = 1'b1;
                    s.first_err = ST_UNSUP;
                end else if (c == CH_DOT) begin
                    if (s.label_len == '0 || s.prev_hyphen) begin
                        s.err_seen  = 1'b1;
                        s.first_err = ST_BAD;
                    end else begin
                        s.label_len = '0;
                        if (s.dot_cnt < DOT_SAT) begin
                            s.dot_cnt = s.dot_cnt + DOT_CNT_W'(1);
                        end
                        s.prev_hyphen = 1'b0;
                    end
                end else if (!(letter || digit || hyphen)) begin
                    s.err_seen  = 1'b1;
                    s.first_err = ST_BAD;
                end else if (s.label_len == '0 && hyphen) begin
                    s.err_seen  = 1'b1;
                    s.first_err = ST_BAD;
                end else begin
                    if (s.label_len <= LABEL_LIMIT) begin
                        s.label_len = s.label_len + LABEL_LEN_W'(1);
                    end
                    if (s.label_len > LABEL_LIMIT) begin
                        s.err_seen  = 1'b1;
                        s.first_err = ST_BAD;
                    end else begin
                        if (!digit) begin
                            s.all_digits = 1'b0;
                        end
                        s.prev_hyphen = hyphen;
                    end
                end
            end
        end

        // Length beats everything, then the first byte error, then the end checks.
        st = ST_OK;
        if (i_last) begin
            if (s.name_len == '0) begin
                st = ST_BAD;
            end else if (s.name_len > NAME_LIMIT) begin
                st = ST_LONG;
            end else if (s.err_seen) begin
                st = s.first_err;
            end else if (s.label_len == '0 || s.prev_hyphen) begin
                st = ST_BAD;
            end else if (s.all_digits && s.dot_cnt == DOT_QUAD) begin
                st = ST_UNSUP;
            end
        end

        o_state             = i_last ? STATE_CLEAR : s;
        o_result.lower_byte = i_no_char ? '0 : c;
        o_result.status     = st;
        o_result.done_res   = i_last;
    end

endmodule

### rtl/dns_hostname_checker_core.sv
// Top level of the DNS host name checker: input register, rule logic, result register.
//
//  Channel  Dir  tdata (low bit up)                  tuser    tlast
//  s_axis   in   char_byte[7:0]                      no_char  last
//  m_axis   out  lower_byte[7:0], status[9:8], zero  -        done_res
//
// One beat in and one beat out per cycle while m_axis does not stall; each beat passes
// the input register, then the rule logic, then the result register.
// The per-name state updates in the same cycle a beat moves to the result register.
// Reset (synchronous, active low) empties both registers and clears the name state.
// A stall on m_axis holds the result; the input register still takes one more beat.
module dns_hostname_checker_core
    import dhc_pkg::*;
#(
    parameter int MAX_NAME_LEN  = 253,
    parameter int MAX_LABEL_LEN = 63
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [CHAR_W-1:0]     s_axis_tdata,   // char_byte
    input  logic                  s_axis_tuser,   // no_char
    input  logic                  s_axis_tlast,   // last
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // lower_byte, status, zero pad
    output logic                  m_axis_tlast    // done_res
);

    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_no_char;
    logic              r_in_last;
    logic              r_out_valid;
    t_result           r_out;
    t_state            r_state;
    t_state            n_state;
    t_result           n_out;
    logic              advance;

    // A beat leaves the input register when the result register is free or drains.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_char    <= s_axis_tdata;
            r_in_no_char <= s_axis_tuser;
            r_in_last    <= s_axis_tlast;
        end
    end

    // Rule logic.
    dhc_check #(
        .MAX_NAME_LEN  (MAX_NAME_LEN),
        .MAX_LABEL_LEN (MAX_LABEL_LEN)
    ) u_check (
        .i_state     (r_state),
        .i_char_byte (r_in_char),
        .i_no_char   (r_in_no_char),
        .i_last      (r_in_last),
        .o_state     (n_state),
        .o_result    (n_out)
    );

    // Name state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_state <= n_state;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - CHAR_W - STATUS_W){1'b0}},
                            r_out.status, r_out.lower_byte};
    assign m_axis_tlast  = r_out.done_res;

endmodule

### rtl/dhc_checker.sv
// Port-level checks of the DNS host name checker, bound to its top level.
`include "dns_hostname_checker_core_macros.svh"

module dhc_checker
    import dhc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tlast
);

    // The input side only back-pressures when a result sits stalled at the output.
    `DHC_ASSERT_NOW(a_stall_only_when_full, i_clk, i_rst_n,
        !s_axis_tready, m_axis_tvalid && !m_axis_tready)

    // Only a beat that ends a name carries a status.
    `DHC_ASSERT_NOW(a_status_only_on_last, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tlast, m_axis_tdata[CHAR_W+STATUS_W-1:CHAR_W] == ST_OK)

    // Pad bits above the status stay zero.
    `DHC_ASSERT_NOW(a_pad_zero, i_clk, i_rst_n,
        m_axis_tvalid, m_axis_tdata[OUT_DATA_W-1:CHAR_W+STATUS_W] == '0)

    // A stalled result beat holds.
    `DHC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

endmodule

bind dns_hostname_checker_core dhc_checker u_dhc_checker (.*);

### verif/dns_hostname_checker_core_tb.sv
// Self-checking testbench for the DNS host name checker core with a stream-side scoreboard.
module dns_hostname_checker_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dhc_pkg::*;

    localparam int NAME_LIMIT     = 253;
    localparam int LABEL_LIMIT    = 63;
    localparam int RANDOM_ITEMS   = 500;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int REPORT_LIMIT   = 10;

    // Bytes outside the letter-digit-hyphen set that the stimulus aims at.
    localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
    localparam logic [CHAR_W-1:0] CH_SLASH      = 8'h2F;

    // Tracks the per-name checking state and holds the result beats still owed by the block.
    class hostname_scoreboard;
        t_state      st;
        t_result     owed_q[$];
        int unsigned mismatches;
        int unsigned beats_checked;
        int unsigned verdicts[4];

        function new();
            st = STATE_CLEAR;
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= REPORT_LIMIT) $display("ERROR: %s", msg);
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Only the first error of a name is kept.
        function void flag(logic [STATUS_W-1:0] code);
            if (!st.err_seen) begin
                st.err_seen  = 1'b1;
                st.first_err = code;
            end
        endfunction

        // Applies the per-byte rules to one folded byte.
        function void absorb_byte(logic [CHAR_W-1:0] ch);
            logic is_letter;
            logic is_digit;
            logic is_hyphen;
            if (st.name_len <= NAME_LIMIT) st.name_len++;
            if (st.err_seen) return;
            if (ch == CH_COLON || ch == CH_LBRACKET || ch == CH_RBRACKET) begin
                flag(ST_UNSUP);
                return;
            end
            if (ch == CH_DOT) begin
                if (st.label_len == 0 || st.prev_hyphen) begin
                    flag(ST_BAD);
                    return;
                end
                st.label_len = '0;
                if (st.dot_cnt < DOT_SAT) st.dot_cnt++;
                st.prev_hyphen = 1'b0;
                return;
            end
            is_letter = (ch >= CH_LOW_A && ch <= CH_LOW_Z);
            is_digit  = (ch >= CH_ZERO && ch <= CH_NINE);
            is_hyphen = (ch == CH_HYPHEN);
            if (!(is_letter || is_digit || is_hyphen)) begin
                flag(ST_BAD);
                return;
            end
            if (st.label_len == 0 && is_hyphen) begin
                flag(ST_BAD);
                return;
            end
            if (st.label_len <= LABEL_LIMIT) st.label_len++;
            if (st.label_len > LABEL_LIMIT) begin
                flag(ST_BAD);
                return;
            end
            if (!is_digit) st.all_digits = 1'b0;
            st.prev_hyphen = is_hyphen;
        endfunction

        // Name-level verdict: length first, then the first byte error, then end-of-name rules.
        function logic [STATUS_W-1:0] verdict();
            if (st.name_len == 0) return ST_BAD;
            if (st.name_len > NAME_LIMIT) return ST_LONG;
            if (st.err_seen) return st.first_err;
            if (st.label_len == 0 || st.prev_hyphen) return ST_BAD;
            if (st.all_digits && st.dot_cnt == DOT_QUAD) return ST_UNSUP;
            return ST_OK;
        endfunction

        // Works out the result beat owed for one accepted input beat.
        function void note_input(logic [CHAR_W-1:0] ch, logic no_char, logic last);
            t_result r;
            r = '0;
            if (!no_char) begin
                if (ch >= CH_UP_A && ch <= CH_UP_Z) ch = ch + CASE_OFFSET;
                r.lower_byte = ch;
                absorb_byte(ch);
            end
            if (last) begin
                r.status   = verdict();
                r.done_res = 1'b1;
                verdicts[r.status]++;
                st = STATE_CLEAR;
            end
            owed_q.push_back(r);
        endfunction

        // Compares one accepted result beat with the oldest owed one.
        function void check_result(logic [OUT_DATA_W-1:0] data, logic done);
            t_result got;
            t_result want;
            got.lower_byte = data[CHAR_W-1:0];
            got.status     = data[CHAR_W+STATUS_W-1:CHAR_W];
            got.done_res   = done;
            beats_checked++;
            if (owed_q.size() == 0) begin
                report($sformatf("unexpected result beat: byte %02h status %0d done %0b",
                                 got.lower_byte, got.status, got.done_res));
                return;
            end
            want = owed_q.pop_front();
            if (got.lower_byte !== want.lower_byte || got.status !== want.status ||
                    got.done_res !== want.done_res) begin
                report($sformatf({"beat %0d: expected byte %02h status %0d done %0b, ",
                                  "got byte %02h status %0d done %0b"}, beats_checked,
                                 want.lower_byte, want.status, want.done_res,
                                 got.lower_byte, got.status, got.done_res));
            end
        endfunction

        function void close_out();
            if (owed_q.size() != 0)
                report($sformatf("%0d result beats never arrived", owed_q.size()));
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [CHAR_W-1:0]     s_axis_tdata;   // char_byte
    logic                  s_axis_tuser;   // no_char
    logic                  s_axis_tlast;   // last
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // lower_byte, status, zero pad
    logic                  m_axis_tlast;   // done_res

    hostname_scoreboard sb;
    logic [CHAR_W-1:0]  name_buf[$];
    bit                 end_empty;
    int unsigned        items_sent;
    int unsigned        burst_left;
    int unsigned        directed_items;
    logic [31:0]        rx_cycle;

    dns_hostname_checker_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // The receiver cycles through always-ready, random and periodic stall patterns.
    always @(negedge i_clk) begin
        rx_cycle = rx_cycle + 1;
        case (rx_cycle[7:6])
            2'd0: m_axis_tready = 1'b1;
            2'd1: m_axis_tready = ($urandom_range(0, 1) == 1);
            2'd2: m_axis_tready = (rx_cycle % 3 != 0);
            default: m_axis_tready = ($urandom_range(0, 3) == 0);
        endcase
    end

    // Accepted input beats feed the predictor.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_input(s_axis_tdata, s_axis_tuser, s_axis_tlast);
    end

    // Accepted result beats are checked against the predictor.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);
    end

    // Watchdog on cycles without any beat moving on either side.
    initial begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("dns_hostname_checker_core test failed");
        $finish;
    end

    // Sends one beat, with a random gap whenever a burst runs out.
    task automatic send_beat(logic [CHAR_W-1:0] ch, logic no_char, logic last);
        int unsigned gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_axis_tdata  = ch;
        s_axis_tuser  = no_char;
        s_axis_tlast  = last;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        if (!no_char || last) items_sent++;
    endtask

    // Sends the name held in name_buf, optionally ended by an empty item.
    task automatic send_name(bit with_skips);
        int n;
        n = name_buf.size();
        for (int i = 0; i < n; i++) begin
            if (with_skips && $urandom_range(0, 15) == 0)
                send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            send_beat(name_buf[i], 1'b0, !end_empty && i == n - 1);
        end
        if (end_empty || n == 0) send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    endtask

    task automatic load_string(string s);
        name_buf.delete();
        end_empty = 1'b0;
        for (int i = 0; i < s.len(); i++) name_buf.push_back(s[i]);
    endtask

    function automatic logic [CHAR_W-1:0] pick_alnum(bit digits_only);
        if (digits_only || $urandom_range(0, 9) < 3)
            return CH_ZERO + 8'($urandom_range(0, 9));
        return (($urandom_range(0, 1) == 1) ? CH_UP_A : CH_LOW_A) + 8'($urandom_range(0, 25));
    endfunction

    // Bytes at the edges of the allowed ranges and the ones with special meaning.
    function automatic logic [CHAR_W-1:0] pick_odd_byte();
        case ($urandom_range(0, 13))
            0:  return CH_DOT;
            1:  return CH_HYPHEN;
            2:  return CH_COLON;
            3:  return CH_LBRACKET;
            4:  return CH_RBRACKET;
            5:  return CH_UNDERSCORE;
            6:  return CH_SPACE;
            7:  return CH_SLASH;
            8:  return CH_UP_A - 8'd1;
            9:  return CH_UP_Z + 8'd1;
            10: return CH_LOW_A - 8'd1;
            11: return CH_LOW_Z + 8'd1;
            12: return CH_NINE + 8'd1;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Appends dot-separated labels; hyphens only inside a label.
    task automatic add_labels(int count, bit digits_only, bit allow_long);
        int len;
        for (int l = 0; l < count; l++) begin
            if (l > 0) name_buf.push_back(CH_DOT);
            if (digits_only)
                len = $urandom_range(1, 3);
            else if (allow_long && $urandom_range(0, 9) == 0)
                len = $urandom_range(LABEL_LIMIT - 8, LABEL_LIMIT + 1);
            else
                len = $urandom_range(1, 10);
            for (int i = 0; i < len; i++) begin
                if (!digits_only && i > 0 && i < len - 1 && $urandom_range(0, 7) == 0)
                    name_buf.push_back(CH_HYPHEN);
                else
                    name_buf.push_back(pick_alnum(digits_only));
            end
        end
    endtask

    // A name right around the length limit, made of long labels.
    task automatic compose_long_name();
        int target;
        int run;
        int label_cap;
        name_buf.delete();
        end_empty = ($urandom_range(0, 3) == 0);
        target    = $urandom_range(NAME_LIMIT - 1, NAME_LIMIT + 3);
        label_cap = $urandom_range(40, LABEL_LIMIT - 1);
        run       = 0;
        while (name_buf.size() < target) begin
            if (run == label_cap) begin
                name_buf.push_back(CH_DOT);
                run = 0;
            end else begin
                name_buf.push_back(pick_alnum(1'b0));
                run++;
            end
        end
        if (name_buf[name_buf.size() - 1] == CH_DOT) name_buf[name_buf.size() - 1] = CH_LOW_A;
    endtask

    // Mostly well-formed names, plus dotted quads, broken names, noise and empty names.
    task automatic compose_name();
        int kind;
        int pos;
        int n_labels;
        name_buf.delete();
        end_empty = ($urandom_range(0, 7) == 0);
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
            add_labels($urandom_range(1, 4), 1'b0, 1'b1);
        end else if (kind < 65) begin
            n_labels = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 5) : 4;
            add_labels(n_labels, 1'b1, 1'b0);
            if ($urandom_range(0, 5) == 0) begin
                pos = $urandom_range(0, name_buf.size() - 1);
                if (name_buf[pos] != CH_DOT) name_buf[pos] = pick_alnum(1'b0);
            end
        end else if (kind < 85) begin
            add_labels($urandom_range(1, 3), 1'b0, 1'b0);
            pos = $urandom_range(0, name_buf.size() - 1);
            case ($urandom_range(0, 2))
                0: name_buf[pos] = pick_odd_byte();
                1: name_buf.insert(pos, pick_odd_byte());
                default: name_buf.push_back(pick_odd_byte());
            endcase
        end else if (kind < 95) begin
            repeat ($urandom_range(1, 8)) name_buf.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 98) begin
            end_empty = 1'b1;
        end else begin
            name_buf.push_back(pick_odd_byte());
        end
    endtask

    // Main sequence: reset, directed names, random names, drain and verdict.
    initial begin
        int unsigned random_start;
        sb             = new();
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = 1'b0;
        s_axis_tlast   = 1'b0;
        m_axis_tready  = 1'b0;
        rx_cycle       = '0;
        items_sent     = 0;
        burst_left     = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: a plain name with upper case, the empty name, a dotted quad,
        // a bracket, leading and trailing hyphen, an empty last label, an ignored
        // item, a top-bit byte and a name closed by an item without a byte.
        load_string("Az.9");
        send_name(1'b0);
        name_buf.delete();
        end_empty = 1'b1;
        send_name(1'b0);
        load_string("1.2.3.4");
        send_name(1'b0);
        load_string("[");
        send_name(1'b0);
        load_string("-a");
        send_name(1'b0);
        load_string("a-");
        send_name(1'b0);
        load_string("a.");
        send_name(1'b0);
        send_beat(8'hA5, 1'b1, 1'b0);
        load_string("Z");
        send_name(1'b0);
        send_beat(8'hFF, 1'b0, 1'b1);
        load_string("q");
        end_empty = 1'b1;
        send_name(1'b0);
        directed_items = items_sent;

        // Random: one name around the length limit, then mixed names.
        random_start = items_sent;
        compose_long_name();
        send_name(1'b1);
        while (items_sent - random_start < RANDOM_ITEMS) begin
            compose_name();
            send_name(1'b1);
        end

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.close_out();

        $display("Checked %0d result beats: %0d directed and %0d random input items.",
                 sb.beats_checked, directed_items, items_sent - directed_items);
        $display("Name verdicts seen: ok %0d, bad argument %0d, too long %0d, unsupported %0d.",
                 sb.verdicts[ST_OK], sb.verdicts[ST_BAD], sb.verdicts[ST_LONG],
                 sb.verdicts[ST_UNSUP]);
        if (sb.mismatches == 0)
            $display("dns_hostname_checker_core test passed");
        else
            $display("dns_hostname_checker_core test failed");
        $finish;
    end

endmodule
